// ===== design/stt_pkg.sv =====
// shared types, constants and character decode for the source text tokenizer
package stt_pkg;

   localparam int OFFSET_BITS    = 32;
   localparam int KEYWORD_CHARS  = 8;
   localparam int FIELD_BITS     = 32;
   localparam int KIND_BITS      = 6;
   localparam int KW_COUNT       = 12;
   localparam int KW_TEXT        = 8;
   localparam int LEN_BITS       = $clog2(KEYWORD_CHARS + 2);
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_BITS-1:0] off_type;
   typedef logic [KIND_BITS-1:0]   kind_type;
   typedef logic [LEN_BITS-1:0]    len_type;
   typedef logic [KW_COUNT-1:0]    kw_vec_type;
   typedef logic [7:0]             char_type;

   localparam off_type OFF_MAX = '1;

   typedef enum logic [2:0] {
      PC_NONE = 3'd0,
      PC_OP   = 3'd1,
      PC_PIPE = 3'd2,
      PC_AMP  = 3'd3,
      PC_NUM  = 3'd4,
      PC_WORD = 3'd5
   } pend_type;

   localparam kind_type KIND_ILLEGAL = 6'd0;
   localparam kind_type KIND_EOF     = 6'd1;
   localparam kind_type KIND_PUNCT   = 6'd2;
   localparam kind_type KIND_OP      = 6'd8;
   localparam kind_type KIND_OP_EQ   = 6'd18;
   localparam kind_type KIND_INC     = 6'd28;
   localparam kind_type KIND_DEC     = 6'd29;
   localparam kind_type KIND_OR      = 6'd30;
   localparam kind_type KIND_AND     = 6'd31;
   localparam kind_type KIND_NUMBER  = 6'd32;
   localparam kind_type KIND_IDENT   = 6'd33;
   localparam kind_type KIND_KEYWORD = 6'd34;

   localparam char_type CH_HASH  = 8'h23;
   localparam char_type CH_PIPE  = 8'h7C;
   localparam char_type CH_AMP   = 8'h26;
   localparam char_type CH_UNDER = 8'h5F;
   localparam char_type CH_EQ    = 8'h3D;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_NL    = 8'h0A;
   localparam char_type CH_EOF   = 8'hFF;

   // keyword text right-aligned, first character highest
   localparam logic [KW_TEXT*8-1:0] KW_WORDS [KW_COUNT] = '{
      "if", "else", "for", "while", "break", "continue",
      "fn", "return", "int", "bool", "true", "false"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd2, 4'd6, 4'd3, 4'd4, 4'd4, 4'd5
   };

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } sel_type;

   typedef struct packed {
      kind_type kind;
      off_type  first;
      off_type  after;
      off_type  line;
      off_type  line_begin;
   } tok_type;

   typedef struct packed {
      logic    two;
      tok_type tok0;
      tok_type tok1;
   } step_type;

   typedef struct packed {
      logic     valid;
      step_type entry;
   } push_type;

   typedef struct packed {
      logic     avail;
      step_type entry;
   } head_type;

   function automatic off_type sat_inc(off_type v);
      return (v == OFF_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(off_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[FIELD_BITS-1:0];
   endfunction

   function automatic sel_type op_code(char_type c);
      sel_type s;
      s.hit = 1'b1;
      unique case (c)
         8'h2B: s.idx = 4'd0;
         8'h2D: s.idx = 4'd1;
         8'h2A: s.idx = 4'd2;
         8'h2F: s.idx = 4'd3;
         8'h25: s.idx = 4'd4;
         8'h3C: s.idx = 4'd5;
         8'h3E: s.idx = 4'd6;
         8'h21: s.idx = 4'd7;
         8'h3A: s.idx = 4'd8;
         8'h3D: s.idx = 4'd9;
         default: begin
            s.hit = 1'b0;
            s.idx = 4'd0;
         end
      endcase
      return s;
   endfunction

   function automatic sel_type punct_code(char_type c);
      sel_type s;
      s.hit = 1'b1;
      unique case (c)
         8'h2C: s.idx = 4'd0;
         8'h3B: s.idx = 4'd1;
         8'h7B: s.idx = 4'd2;
         8'h7D: s.idx = 4'd3;
         8'h28: s.idx = 4'd4;
         8'h29: s.idx = 4'd5;
         default: begin
            s.hit = 1'b0;
            s.idx = 4'd0;
         end
      endcase
      return s;
   endfunction

   function automatic logic is_digit(char_type c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(char_type c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_ident(char_type c);
      return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
   endfunction

   // character of keyword k at position pos, zero past its end
   function automatic char_type kw_char(int k, len_type pos);
      int n;
      n = int'(KW_LEN[k]) - 1 - int'(pos);
      if (n < 0) begin
         return 8'h00;
      end
      return KW_WORDS[k][n*8 +: 8];
   endfunction

endpackage

// ===== design/stt_ifs.sv =====
// request and response channel interfaces of the source text tokenizer
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;
   logic       ends_source;

   modport source (output valid, output src_byte, output ends_source, input ready);
   modport sink (input valid, input src_byte, input ends_source, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  token_kind;
   logic [FIELD_BITS-1:0] token_first;
   logic [FIELD_BITS-1:0] token_after;
   logic [FIELD_BITS-1:0] line_number;
   logic [FIELD_BITS-1:0] line_offset;
   logic                  run_last;

   modport source (output valid, output token_kind, output token_first, output token_after,
                   output line_number, output line_offset, output run_last, input ready);
   modport sink (input valid, input token_kind, input token_first, input token_after,
                 input line_number, input line_offset, input run_last, output ready);
endinterface

// ===== design/source_text_tokenizer.sv =====
// top level of the source text tokenizer: front end, step queue and output stage
// The tokenizer takes one source byte per transfer on req_port and returns tokens on
// rsp_port, each with its kind, start and end offset, line number and line start.
// A byte is taken in every cycle while the four-step queue between the lexer and the
// output stage has room; the lexer handles each byte in the cycle it is taken. A byte
// yields zero, one or two tokens, and the output stage sends one token per cycle while
// rsp_port is ready, so two-token bytes slow the byte intake once the queue fills.
// The first token of a byte is written into the step queue when the byte transfers and
// is then registered in the output stage, which offers it on rsp_port. A byte with
// ends_source set flushes the pending token and restarts offsets and line count.
// There is no start-up clearing: the block is ready the cycle after reset.
module source_text_tokenizer import stt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_port,
   stt_rsp_if.source rsp_port
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   stt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .push_out   (push),
      .queue_full (queue_full)
   );

   stt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .full     (queue_full),
      .head_out (head),
      .pop      (pop)
   );

   stt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_in  (head),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

endmodule

// ===== design/stt_front.sv =====
// lexer front end: accepts bytes, tracks the pending token and builds token steps
module stt_front import stt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   stt_req_if.sink  req_port,
   output push_type push_out,
   input  logic     queue_full
);

   pend_type   pclass_ff, pclass_in;
   char_type   pchar_ff, pchar_in;
   off_type    pbeg_ff, pbeg_in;
   len_type    wlen_ff, wlen_in;
   kw_vec_type match_ff, match_in;
   logic       comment_ff, comment_in;
   off_type    line_ff, line_in;
   off_type    lbeg_ff, lbeg_in;
   off_type    pos_ff, pos_in;

   logic       accept;
   char_type   c;
   off_type    p1;
   logic       fresh;
   logic [1:0] n;
   tok_type    toks [2];
   sel_type    opsel;
   sel_type    opsel_end;
   sel_type    csel;
   sel_type    psel;

   function automatic tok_type mk(kind_type kind, off_type first, off_type after,
                                  off_type line, off_type lbeg);
      tok_type t;
      t.kind       = kind;
      t.first      = first;
      t.after      = after;
      t.line       = line;
      t.line_begin = lbeg;
      return t;
   endfunction

   function automatic kind_type word_kind(len_type wlen, kw_vec_type match);
      kind_type kind;
      kind = KIND_IDENT;
      if (wlen <= len_type'(KEYWORD_CHARS)) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            if (match[k] && (wlen == len_type'(KW_LEN[k]))) begin
               kind = KIND_KEYWORD + kind_type'(k);
            end
         end
      end
      return kind;
   endfunction

   // pending token ended by a byte that does not extend it
   function automatic tok_type flush_tok(pend_type cls, logic [3:0] op_idx, off_type pbeg,
                                         off_type here, off_type line, off_type lbeg,
                                         len_type wlen, kw_vec_type match);
      tok_type t;
      unique case (cls)
         PC_OP:          t = mk(KIND_OP + kind_type'(op_idx), pbeg, sat_inc(pbeg), line, lbeg);
         PC_PIPE,
         PC_AMP:         t = mk(KIND_ILLEGAL, pbeg, sat_inc(pbeg), line, lbeg);
         PC_NUM:         t = mk(KIND_NUMBER, pbeg, here, line, lbeg);
         PC_WORD:        t = mk(word_kind(wlen, match), pbeg, here, line, lbeg);
         default:        t = mk(KIND_ILLEGAL, pbeg, sat_inc(pbeg), line, lbeg);
      endcase
      return t;
   endfunction

   assign req_port.ready = !queue_full;
   assign accept         = req_port.valid && !queue_full;

   always_comb begin
      c          = req_port.src_byte;
      p1         = sat_inc(pos_ff);
      pclass_in  = pclass_ff;
      pchar_in   = pchar_ff;
      pbeg_in    = pbeg_ff;
      wlen_in    = wlen_ff;
      match_in   = match_ff;
      comment_in = comment_ff;
      line_in    = line_ff;
      lbeg_in    = lbeg_ff;
      pos_in     = p1;
      fresh      = 1'b1;
      n          = 2'd0;
      toks[0]    = '0;
      toks[1]    = '0;
      opsel      = op_code(pchar_ff);
      csel       = op_code(c);
      psel       = punct_code(c);

      if (comment_ff) begin
         if (c == CH_NL) begin
            comment_in = 1'b0;
         end else begin
            fresh = 1'b0;
         end
      end else begin
         unique case (pclass_ff)
            PC_OP: begin
               if (c == CH_EQ) begin
                  toks[0]   = mk(KIND_OP_EQ + kind_type'(opsel.idx), pbeg_ff, p1, line_ff,
                                 lbeg_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  fresh     = 1'b0;
               end else if ((c == pchar_ff) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                  toks[0]   = mk((c == CH_PLUS) ? KIND_INC : KIND_DEC, pbeg_ff, p1, line_ff,
                                 lbeg_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  fresh     = 1'b0;
               end else begin
                  toks[0]   = flush_tok(pclass_ff, opsel.idx, pbeg_ff, pos_ff, line_ff, lbeg_ff,
                                        wlen_ff, match_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  wlen_in   = '0;
               end
            end
            PC_PIPE,
            PC_AMP: begin
               if (c == ((pclass_ff == PC_PIPE) ? CH_PIPE : CH_AMP)) begin
                  toks[0]   = mk((pclass_ff == PC_PIPE) ? KIND_OR : KIND_AND, pbeg_ff, p1,
                                 line_ff, lbeg_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  fresh     = 1'b0;
               end else begin
                  toks[0]   = flush_tok(pclass_ff, opsel.idx, pbeg_ff, pos_ff, line_ff, lbeg_ff,
                                        wlen_ff, match_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  wlen_in   = '0;
               end
            end
            PC_NUM: begin
               if (is_digit(c)) begin
                  fresh = 1'b0;
               end else begin
                  toks[0]   = flush_tok(pclass_ff, opsel.idx, pbeg_ff, pos_ff, line_ff, lbeg_ff,
                                        wlen_ff, match_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  wlen_in   = '0;
               end
            end
            PC_WORD: begin
               if (is_ident(c)) begin
                  fresh = 1'b0;
                  if (wlen_ff < len_type'(KEYWORD_CHARS)) begin
                     for (int k = 0; k < KW_COUNT; k++) begin
                        match_in[k] = match_ff[k] && (kw_char(k, wlen_ff) == c);
                     end
                  end
                  if (wlen_ff < len_type'(KEYWORD_CHARS + 1)) begin
                     wlen_in = wlen_ff + 1'b1;
                  end
               end else begin
                  toks[0]   = flush_tok(pclass_ff, opsel.idx, pbeg_ff, pos_ff, line_ff, lbeg_ff,
                                        wlen_ff, match_ff);
                  n         = 2'd1;
                  pclass_in = PC_NONE;
                  wlen_in   = '0;
               end
            end
            default: begin
               pclass_in = PC_NONE;
            end
         endcase
      end

      if (fresh) begin
         if (c == CH_SPACE) begin
            pos_in = p1;
         end else if (c == CH_NL) begin
            line_in = sat_inc(line_ff);
            lbeg_in = p1;
         end else if (c == CH_HASH) begin
            comment_in = 1'b1;
         end else if ((c == CH_PIPE) || (c == CH_AMP)) begin
            pclass_in = (c == CH_PIPE) ? PC_PIPE : PC_AMP;
            pbeg_in   = pos_ff;
         end else if (c == CH_EOF) begin
            toks[n[0]] = mk(KIND_EOF, pos_ff, p1, line_ff, lbeg_ff);
            n          = n + 2'd1;
         end else if (csel.hit) begin
            pclass_in = PC_OP;
            pchar_in  = c;
            pbeg_in   = pos_ff;
         end else if (psel.hit) begin
            toks[n[0]] = mk(KIND_PUNCT + kind_type'(psel.idx), pos_ff, p1, line_ff, lbeg_ff);
            n          = n + 2'd1;
         end else if (is_digit(c)) begin
            pclass_in = PC_NUM;
            pbeg_in   = pos_ff;
         end else if (is_alpha(c) || (c == CH_UNDER)) begin
            pclass_in = PC_WORD;
            pbeg_in   = pos_ff;
            wlen_in   = len_type'(1);
            for (int k = 0; k < KW_COUNT; k++) begin
               match_in[k] = (kw_char(k, '0) == c);
            end
         end else begin
            toks[n[0]] = mk(KIND_ILLEGAL, pos_ff, p1, line_ff, lbeg_ff);
            n          = n + 2'd1;
         end
      end

      opsel_end = op_code(pchar_in);
      if (req_port.ends_source) begin
         if (pclass_in != PC_NONE) begin
            toks[n[0]] = flush_tok(pclass_in, opsel_end.idx, pbeg_in, p1, line_in, lbeg_in,
                                   wlen_in, match_in);
            n          = n + 2'd1;
         end
         pclass_in  = PC_NONE;
         pchar_in   = '0;
         pbeg_in    = '0;
         wlen_in    = '0;
         comment_in = 1'b0;
         line_in    = off_type'(1);
         lbeg_in    = '0;
         pos_in     = '0;
      end
   end

   assign push_out.valid      = accept && (n != 2'd0);
   assign push_out.entry.two  = (n == 2'd2);
   assign push_out.entry.tok0 = toks[0];
   assign push_out.entry.tok1 = toks[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pclass_ff  <= PC_NONE;
         pchar_ff   <= '0;
         pbeg_ff    <= '0;
         wlen_ff    <= '0;
         comment_ff <= 1'b0;
         line_ff    <= off_type'(1);
         lbeg_ff    <= '0;
         pos_ff     <= '0;
      end else if (accept) begin
         pclass_ff  <= pclass_in;
         pchar_ff   <= pchar_in;
         pbeg_ff    <= pbeg_in;
         wlen_ff    <= wlen_in;
         comment_ff <= comment_in;
         line_ff    <= line_in;
         lbeg_ff    <= lbeg_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         match_ff <= match_in;
      end
   end

`ifndef SYNTH
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_port.ends_source |=> (pclass_ff == PC_NONE) && (pos_ff == '0) &&
                                          !comment_ff && (line_ff == off_type'(1)))
      else $error("counters not restarted after end of source");

   a_word_has_length: assert property (@(posedge clock) disable iff (reset)
      (pclass_ff == PC_WORD) |-> (wlen_ff != '0))
      else $error("pending word with zero length");
`endif

endmodule

// ===== design/stt_queue.sv =====
// small fifo of token steps between the lexer front end and the output stage
module stt_queue import stt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   output head_type head_out,
   input  logic     pop
);

   step_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full           = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_out.avail = (count_ff != '0);
   assign head_out.entry = slot_ff[rd_ptr_ff];
   assign do_push        = push_in.valid && !full;
   assign do_pop         = pop && head_out.avail;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_in.valid |-> !full)
      else $error("step pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// ===== design/stt_back.sv =====
// output stage: sends the tokens of each step one per transfer
module stt_back import stt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  head_type  head_in,
   output logic      pop,
   stt_rsp_if.source rsp_port
);

   logic    out_valid_ff, out_valid_in;
   logic    phase_ff, phase_in;
   tok_type out_tok_ff, out_tok_in;
   logic    out_last_ff, out_last_in;
   logic    load;
   logic    fin;

   assign load = !out_valid_ff || rsp_port.ready;
   assign fin  = !head_in.entry.two || phase_ff;
   assign pop  = load && head_in.avail && fin;

   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      out_tok_in   = out_tok_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = head_in.avail;
         if (head_in.avail) begin
            out_tok_in  = phase_ff ? head_in.entry.tok1 : head_in.entry.tok0;
            out_last_in = fin;
            phase_in    = !fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff  <= out_tok_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.token_kind  = out_tok_ff.kind;
   assign rsp_port.token_first = to_field(out_tok_ff.first);
   assign rsp_port.token_after = to_field(out_tok_ff.after);
   assign rsp_port.line_number = to_field(out_tok_ff.line);
   assign rsp_port.line_offset = to_field(out_tok_ff.line_begin);
   assign rsp_port.run_last    = out_last_ff;

`ifndef SYNTH
   a_second_token_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_in.avail && head_in.entry.two)
      else $error("second token pending without a two-token step at queue head");
`endif

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the source text tokenizer: byte stream in, checked tokens out
module tb;
   import stt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 200;
   localparam int KIND_COUNT  = KIND_KEYWORD + KW_COUNT;

   localparam char_type CH_NUL = 8'h00;
   localparam char_type CH_LA  = "a";
   localparam char_type CH_UA  = "A";
   localparam char_type CH_D0  = "0";
   localparam char_type CH_X   = "x";

   typedef struct {
      kind_type              kind;
      logic [FIELD_BITS-1:0] first;
      logic [FIELD_BITS-1:0] after;
      logic [FIELD_BITS-1:0] line;
      logic [FIELD_BITS-1:0] lbeg;
      logic                  closes;
   } token_type;

   logic clock;
   logic reset;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   source_text_tokenizer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   string kw_names [KW_COUNT] = '{"if", "else", "for", "while", "break", "continue",
                                  "fn", "return", "int", "bool", "true", "false"};
   string op_set    = "+-*/%<>!:=";
   string punct_set = ",;{}()";
   string odd_set   = "\t\r@$\"'.?[]\\^`~";

   // lexer state mirror
   off_type  lx_pos;
   off_type  lx_line;
   off_type  lx_lbeg;
   off_type  lx_pbeg;
   pend_type lx_pend;
   char_type lx_pch;
   char_type lx_word [KEYWORD_CHARS];
   int       lx_wlen;
   bit       lx_cmt;

   token_type due_tokens[$];
   token_type byte_tokens[$];
   char_type  text_q[$];

   int          err_count;
   int          reports;
   int          tokens_checked;
   int          bytes_sent;
   int          bytes_used;
   int          sources_done;
   int          cycle_count;
   logic [63:0] kinds_seen;
   bit          src_gaps;
   bit          rsp_gaps;
   int          hold_len;
   bit          holding;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t timeout with %0d tokens still due", $time, due_tokens.size());
         $display("** source_text_tokenizer: FAILED **");
         $finish;
      end
   end

   // ---------------- lexer prediction ----------------

   function automatic off_type bump(off_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic int op_index(char_type c);
      for (int i = 0; i < op_set.len(); i++) begin
         if (op_set[i] == c) return i;
      end
      return -1;
   endfunction

   function automatic int punct_index(char_type c);
      for (int i = 0; i < punct_set.len(); i++) begin
         if (punct_set[i] == c) return i;
      end
      return -1;
   endfunction

   function automatic bit is_num_ch(char_type c);
      return c >= CH_D0 && c <= CH_D0 + 9;
   endfunction

   function automatic bit is_letter(char_type c);
      return (c >= CH_LA && c <= CH_LA + 25) || (c >= CH_UA && c <= CH_UA + 25);
   endfunction

   function automatic bit is_word_ch(char_type c);
      return is_num_ch(c) || is_letter(c) || c == CH_UNDER;
   endfunction

   function automatic void lexer_clear();
      lx_pos  = '0;
      lx_line = off_type'(1);
      lx_lbeg = '0;
      lx_pbeg = '0;
      lx_pend = PC_NONE;
      lx_pch  = '0;
      lx_wlen = 0;
      lx_cmt  = 1'b0;
      foreach (lx_word[i]) lx_word[i] = '0;
   endfunction

   function automatic void add_tok(kind_type k, off_type f, off_type a);
      token_type t;
      t.kind   = k;
      t.first  = f;
      t.after  = a;
      t.line   = lx_line;
      t.lbeg   = lx_lbeg;
      t.closes = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   function automatic void word_push(char_type c);
      if (lx_wlen < KEYWORD_CHARS) lx_word[lx_wlen] = c;
      if (lx_wlen < KEYWORD_CHARS + 1) lx_wlen++;
   endfunction

   function automatic kind_type word_kind();
      bit same;
      if (lx_wlen > KEYWORD_CHARS) return KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw_names[k].len() == lx_wlen) begin
            same = 1'b1;
            for (int i = 0; i < lx_wlen; i++) begin
               if (kw_names[k][i] != lx_word[i]) same = 1'b0;
            end
            if (same) return KIND_KEYWORD + kind_type'(k);
         end
      end
      return KIND_IDENT;
   endfunction

   // pending token ended by a byte that does not extend it
   function automatic void flush_pending(off_type here);
      case (lx_pend)
         PC_OP: add_tok(KIND_OP + kind_type'(op_index(lx_pch)), lx_pbeg, bump(lx_pbeg));
         PC_PIPE, PC_AMP: add_tok(KIND_ILLEGAL, lx_pbeg, bump(lx_pbeg));
         PC_NUM: add_tok(KIND_NUMBER, lx_pbeg, here);
         PC_WORD: add_tok(word_kind(), lx_pbeg, here);
         default: begin
         end
      endcase
      lx_pend = PC_NONE;
      lx_wlen = 0;
   endfunction

   // returns 1 when the byte is more than blank space or comment text
   function automatic bit lex_byte(char_type c, bit closes);
      bit      fresh;
      bit      used;
      off_type p;
      p     = lx_pos;
      fresh = 1'b1;
      used  = !(lx_cmt && c != CH_NL) && c != CH_SPACE;
      byte_tokens.delete();
      if (lx_cmt) begin
         if (c == CH_NL) lx_cmt = 1'b0;
         else fresh = 1'b0;
      end else begin
         case (lx_pend)
            PC_OP: begin
               if (c == CH_EQ) begin
                  add_tok(KIND_OP_EQ + kind_type'(op_index(lx_pch)), lx_pbeg, bump(p));
                  lx_pend = PC_NONE;
                  fresh   = 1'b0;
               end else if (c == lx_pch && (c == CH_PLUS || c == CH_MINUS)) begin
                  add_tok(c == CH_PLUS ? KIND_INC : KIND_DEC, lx_pbeg, bump(p));
                  lx_pend = PC_NONE;
                  fresh   = 1'b0;
               end else begin
                  flush_pending(p);
               end
            end
            PC_PIPE, PC_AMP: begin
               if (c == (lx_pend == PC_PIPE ? CH_PIPE : CH_AMP)) begin
                  add_tok(lx_pend == PC_PIPE ? KIND_OR : KIND_AND, lx_pbeg, bump(p));
                  lx_pend = PC_NONE;
                  fresh   = 1'b0;
               end else begin
                  flush_pending(p);
               end
            end
            PC_NUM: begin
               if (is_num_ch(c)) fresh = 1'b0;
               else flush_pending(p);
            end
            PC_WORD: begin
               if (is_word_ch(c)) begin
                  word_push(c);
                  fresh = 1'b0;
               end else begin
                  flush_pending(p);
               end
            end
            default: begin
            end
         endcase
      end
      if (fresh) begin
         if (c == CH_SPACE) begin
         end else if (c == CH_NL) begin
            lx_line = bump(lx_line);
            lx_lbeg = bump(p);
         end else if (c == CH_HASH) begin
            lx_cmt = 1'b1;
         end else if (c == CH_PIPE || c == CH_AMP) begin
            lx_pend = (c == CH_PIPE) ? PC_PIPE : PC_AMP;
            lx_pbeg = p;
         end else if (c == CH_EOF) begin
            add_tok(KIND_EOF, p, bump(p));
         end else if (op_index(c) >= 0) begin
            lx_pend = PC_OP;
            lx_pch  = c;
            lx_pbeg = p;
         end else if (punct_index(c) >= 0) begin
            add_tok(KIND_PUNCT + kind_type'(punct_index(c)), p, bump(p));
         end else if (is_num_ch(c)) begin
            lx_pend = PC_NUM;
            lx_pbeg = p;
         end else if (is_letter(c) || c == CH_UNDER) begin
            lx_pend = PC_WORD;
            lx_pbeg = p;
            lx_wlen = 0;
            word_push(c);
         end else begin
            add_tok(KIND_ILLEGAL, p, bump(p));
         end
      end
      lx_pos = bump(p);
      if (closes) begin
         flush_pending(lx_pos);
         lexer_clear();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].closes = 1'b1;
      foreach (byte_tokens[i]) due_tokens.push_back(byte_tokens[i]);
      return used;
   endfunction

   // ---------------- source text generation ----------------

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic char_type word_char(bit lead);
      int r;
      r = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return CH_LA + char_type'(r);
      if (r < 52) return CH_UA + char_type'(r - 26);
      if (r == 52) return CH_UNDER;
      return CH_D0 + char_type'(r - 53);
   endfunction

   function automatic void put_fragment();
      int       r;
      int       n;
      char_type c;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         put_str(kw_names[$urandom_range(0, KW_COUNT-1)]);
      end else if (r < 20) begin
         n = $urandom_range(0, KW_COUNT-1);
         if ($urandom_range(0, 1)) begin
            put_str(kw_names[n]);
            text_q.push_back(word_char(1'b0));
         end else begin
            put_str(kw_names[n].substr(0, kw_names[n].len() - 2));
         end
      end else if (r < 35) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         text_q.push_back(word_char(1'b1));
         repeat (n - 1) text_q.push_back(word_char(1'b0));
      end else if (r < 45) begin
         repeat ($urandom_range(1, 5)) begin
            text_q.push_back(CH_D0 + char_type'($urandom_range(0, 9)));
         end
      end else if (r < 53) begin
         text_q.push_back(op_set[$urandom_range(0, 9)]);
      end else if (r < 59) begin
         text_q.push_back(op_set[$urandom_range(0, 9)]);
         text_q.push_back(CH_EQ);
      end else if (r < 63) begin
         c = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
         text_q.push_back(c);
         text_q.push_back(c);
      end else if (r < 67) begin
         c = $urandom_range(0, 1) ? CH_PIPE : CH_AMP;
         text_q.push_back(c);
         text_q.push_back(c);
      end else if (r < 70) begin
         text_q.push_back($urandom_range(0, 1) ? CH_PIPE : CH_AMP);
      end else if (r < 73) begin
         c = op_set[$urandom_range(0, 9)];
         text_q.push_back(c);
         text_q.push_back(c);
      end else if (r < 81) begin
         text_q.push_back(punct_set[$urandom_range(0, 5)]);
      end else if (r < 85) begin
         text_q.push_back(CH_NL);
      end else if (r < 89) begin
         text_q.push_back(CH_HASH);
         repeat ($urandom_range(0, 10)) begin
            c = char_type'($urandom_range(0, 255));
            text_q.push_back(c == CH_NL ? CH_X : c);
         end
         if ($urandom_range(0, 4) != 0) text_q.push_back(CH_NL);
      end else if (r < 91) begin
         text_q.push_back(CH_EOF);
      end else if (r < 95) begin
         case ($urandom_range(0, 3))
            0: text_q.push_back(char_type'($urandom_range(8'h80, 8'hFE)));
            1: text_q.push_back(odd_set[$urandom_range(0, odd_set.len() - 1)]);
            2: text_q.push_back(char_type'($urandom_range(1, 31)));
            default: text_q.push_back(CH_NUL);
         endcase
      end else begin
         text_q.push_back(char_type'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 9);
      if (r < 4) text_q.push_back(CH_SPACE);
      else if (r == 4) text_q.push_back(CH_NL);
   endfunction

   function automatic void build_source();
      int target;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 250) : $urandom_range(4, 60);
      text_q.delete();
      while (text_q.size() < target) put_fragment();
   endfunction

   // ---------------- request side ----------------

   task automatic send_byte(char_type c, bit closes);
      if (src_gaps && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.src_byte    <= c;
      req_ch.ends_source <= closes;
      if (lex_byte(c, closes)) bytes_used++;
      bytes_sent++;
      if (closes) sources_done++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_text(bit closes);
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], closes && i == text_q.size() - 1);
      end
   endtask

   // ---------------- response side ----------------

   initial begin : rsp_ready_drive
      int n;
      rsp_ch.ready <= 1'b0;
      repeat (2) @(posedge clock);
      forever begin
         if (hold_len > 0) begin
            n        = hold_len;
            hold_len = 0;
            holding  = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
            holding = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   function automatic void field_check(string name, logic [FIELD_BITS-1:0] exp_v,
                                       logic [FIELD_BITS-1:0] got_v);
      if (got_v !== exp_v) begin
         err_count++;
         if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t token %0d %s mismatch: expected %0d actual %0d",
                     $time, tokens_checked, name, exp_v, got_v);
         end
      end
   endfunction

   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_tokens.size() == 0) begin
            err_count++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t unexpected token: expected none actual kind %0d first %0d",
                        $time, rsp_ch.token_kind, rsp_ch.token_first);
            end
         end else begin
            want = due_tokens.pop_front();
            field_check("token_kind", want.kind, rsp_ch.token_kind);
            field_check("token_first", want.first, rsp_ch.token_first);
            field_check("token_after", want.after, rsp_ch.token_after);
            field_check("line_number", want.line, rsp_ch.line_number);
            field_check("line_offset", want.lbeg, rsp_ch.line_offset);
            field_check("run_last", want.closes, rsp_ch.run_last);
            kinds_seen[want.kind] = 1'b1;
         end
         tokens_checked++;
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      text_q.delete();
      put_str("if a>=9||b&c++\n");
      put_str("**");
      text_q.push_back(CH_EOF);
      text_q.push_back(CH_NUL);
      text_q.push_back(8'h80);
      text_q.push_back(CH_HASH);
      text_q.push_back(CH_EOF);
      // source closes while inside a comment
      send_text(1'b1);
      text_q.delete();
      put_str("_z9");
      // source closes with a word still pending
      send_text(1'b1);
   endtask

   task automatic test_random_sources(int goal);
      src_gaps = 1'b1;
      rsp_gaps = 1'b1;
      while (bytes_sent < goal) begin
         build_source();
         send_text($urandom_range(0, 9) != 0);
      end
   endtask

   task automatic test_output_hold(int count);
      int start;
      start    = bytes_sent;
      src_gaps = 1'b0;
      hold_len = 400;
      while (bytes_sent - start < count || holding || hold_len > 0) begin
         build_source();
         send_text(1'b1);
      end
   endtask

   task automatic test_full_rate(int count);
      int start;
      start    = bytes_sent;
      src_gaps = 1'b0;
      rsp_gaps = 1'b0;
      while (bytes_sent - start < count) begin
         build_source();
         send_text(1'b1);
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.src_byte    <= '0;
      req_ch.ends_source <= 1'b0;
      err_count      = 0;
      reports        = 0;
      tokens_checked = 0;
      bytes_sent     = 0;
      bytes_used     = 0;
      sources_done   = 0;
      cycle_count    = 0;
      kinds_seen     = '0;
      src_gaps       = 1'b0;
      rsp_gaps       = 1'b0;
      hold_len       = 0;
      holding        = 1'b0;
      lexer_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_sources(1250);
      test_output_hold(150);
      test_full_rate(150);

      req_ch.valid <= 1'b0;
      while (due_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("run covered %0d bytes (%0d significant) over %0d closed sources",
               bytes_sent, bytes_used, sources_done);
      $display("%0d tokens checked, %0d of %0d token kinds seen, %0d mismatches",
               tokens_checked, $countones(kinds_seen), KIND_COUNT, err_count);
      if (err_count == 0) begin
         $display("** source_text_tokenizer: PASSED **");
      end else begin
         $display("** source_text_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
